@@ hw/rtl/t1_response_block_framer_macros.svh @@
// ----------------------------------------------------------------------------
// t1 response block framer assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef T1_RESPONSE_BLOCK_FRAMER_MACROS_SVH
`define T1_RESPONSE_BLOCK_FRAMER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define T1RBF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("t1rbf same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define T1RBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("t1rbf next-cycle check failed");

`endif

@@ hw/rtl/t1rbf_pkg.sv @@
// ----------------------------------------------------------------------------
// t1rbf_pkg
// constants, types and byte functions of the t1 response block framer
// ----------------------------------------------------------------------------
package t1rbf_pkg;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOR  = 16'hFFFF;

   localparam logic [7:0] PCB_R_RESP  = 8'hE0;
   localparam logic [7:0] PCB_S_SET   = 8'b0010_0000;
   localparam logic [7:0] PCB_I_MASK  = 8'b1000_0000;
   localparam logic [7:0] PCB_RS_MASK = 8'b1100_0000;
   localparam logic [7:0] PCB_R_CODE  = 8'b1000_0000;
   localparam logic [7:0] PCB_I_FLIP  = 8'h01;

   localparam logic OP_HEADER  = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // one byte handed from the sequencer to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } emit_type;

   // reflected crc-16/x-25 update over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] resp_pcb(input logic [7:0] pcb);
      logic [7:0] r;
      if ((pcb & PCB_I_MASK) == 8'h00) begin
         r = pcb ^ PCB_I_FLIP;
      end else if ((pcb & PCB_RS_MASK) == PCB_R_CODE) begin
         r = PCB_R_RESP;
      end else begin
         r = pcb | PCB_S_SET;
      end
      return r;
   endfunction

   function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
      return {b[3:0], b[7:4]};
   endfunction

endpackage

@@ hw/rtl/t1rbf_ifs.sv @@
// ----------------------------------------------------------------------------
// t1rbf channel interfaces
// valid/ready channels for request items and framed response bytes
// ----------------------------------------------------------------------------
interface t1rbf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_nad;
   logic [7:0] rx_pcb;
   logic [7:0] resp_len;
   logic [7:0] data_byte;

   modport source (output valid, op, rx_nad, rx_pcb, resp_len, data_byte, input ready);
   modport sink   (input valid, op, rx_nad, rx_pcb, resp_len, data_byte, output ready);
endinterface

interface t1rbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

@@ hw/rtl/t1rbf_seq.sv @@
// ----------------------------------------------------------------------------
// t1rbf_seq
// holds one request item and walks it out one block byte per cycle while the output register takes bytes,
// keeping the running crc and the open block state
// ----------------------------------------------------------------------------
`include "t1_response_block_framer_macros.svh"

module t1rbf_seq (
   input  logic                clock,
   input  logic                reset,
   t1rbf_req_if.sink           req_ch,
   input  logic                take,
   output t1rbf_pkg::emit_type emit
);

   typedef enum logic [5:0] {
      S_NAD   = 6'b000001,
      S_PCB   = 6'b000010,
      S_LEN   = 6'b000100,
      S_DATA  = 6'b001000,
      S_CRCLO = 6'b010000,
      S_CRCHI = 6'b100000
   } step_type;

   step_type    step_ff, step_in;
   logic        hold_ff, hold_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  left_ff, left_in;
   logic        open_ff, open_in;
   logic [7:0]  nad_ff, nad_in;
   logic [7:0]  pcb_ff, pcb_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  dat_ff, dat_in;

   logic [7:0]  cur_byte;
   logic        cur_last;
   logic        cur_emits;
   logic        fire;
   logic        done;
   logic        accept;
   logic [15:0] crc_base;
   logic [15:0] crc_upd;
   logic [15:0] crc_fin;

   assign crc_fin  = crc_ff ^ t1rbf_pkg::CRC_XOR;
   assign crc_base = (step_ff == S_NAD) ? t1rbf_pkg::CRC_INIT : crc_ff;
   assign crc_upd  = t1rbf_pkg::crc_byte(crc_base, cur_byte);

   always_comb begin
      cur_byte  = dat_ff;
      cur_last  = 1'b0;
      cur_emits = 1'b1;
      case (step_ff)
         S_NAD:   cur_byte = t1rbf_pkg::swap_nibbles(nad_ff);
         S_PCB:   cur_byte = t1rbf_pkg::resp_pcb(pcb_ff);
         S_LEN:   cur_byte = len_ff;
         S_DATA: begin
            cur_byte  = dat_ff;
            // payload outside an open block is dropped
            cur_emits = open_ff;
         end
         S_CRCLO: cur_byte = crc_fin[7:0];
         S_CRCHI: begin
            cur_byte = crc_fin[15:8];
            cur_last = 1'b1;
         end
         default: cur_emits = 1'b0;
      endcase
   end

   assign emit.valid = hold_ff & cur_emits;
   assign emit.data  = cur_byte;
   assign emit.last  = cur_last;
   assign fire       = hold_ff & (~cur_emits | take);

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      left_in = left_ff;
      open_in = open_ff;
      done    = 1'b0;
      if (fire) begin
         case (step_ff)
            S_NAD: begin
               crc_in  = crc_upd;
               step_in = S_PCB;
            end
            S_PCB: begin
               crc_in  = crc_upd;
               step_in = S_LEN;
            end
            S_LEN: begin
               crc_in = crc_upd;
               if (len_ff == 8'd0) begin
                  step_in = S_CRCLO;
               end else begin
                  left_in = len_ff;
                  open_in = 1'b1;
                  done    = 1'b1;
               end
            end
            S_DATA: begin
               if (open_ff) begin
                  crc_in  = crc_upd;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     // last payload byte, only the crc remains
                     open_in = 1'b0;
                     step_in = S_CRCLO;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  done = 1'b1;
               end
            end
            S_CRCLO: step_in = S_CRCHI;
            S_CRCHI: begin
               open_in = 1'b0;
               left_in = 8'd0;
               done    = 1'b1;
            end
            default: done = 1'b1;
         endcase
      end
   end

   // a new item enters while the held one finishes its last byte
   assign req_ch.ready = ~hold_ff | done;
   assign accept       = req_ch.valid & req_ch.ready;

   always_comb begin
      hold_in = hold_ff;
      nad_in  = nad_ff;
      pcb_in  = pcb_ff;
      len_in  = len_ff;
      dat_in  = dat_ff;
      if (accept) begin
         hold_in = 1'b1;
         nad_in  = req_ch.rx_nad;
         pcb_in  = req_ch.rx_pcb;
         len_in  = req_ch.resp_len;
         dat_in  = req_ch.data_byte;
      end else if (done) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         step_ff <= S_NAD;
         crc_ff  <= t1rbf_pkg::CRC_INIT;
         left_ff <= 8'd0;
         open_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
         if (accept) begin
            step_ff <= (req_ch.op == t1rbf_pkg::OP_HEADER) ? S_NAD : S_DATA;
         end else begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      nad_ff <= nad_in;
      pcb_ff <= pcb_in;
      len_ff <= len_in;
      dat_ff <= dat_in;
   end

   `T1RBF_ASSERT_SAME(a_open_has_bytes, open_ff, left_ff != 8'd0)
   `T1RBF_ASSERT_NEXT(a_crc_lo_then_hi, fire && (step_ff == S_CRCLO), hold_ff && (step_ff == S_CRCHI))
   `T1RBF_ASSERT_NEXT(a_block_closed, fire && (step_ff == S_CRCHI), !open_ff && (left_ff == 8'd0))

endmodule

@@ hw/rtl/t1rbf_out.sv @@
// ----------------------------------------------------------------------------
// t1rbf_out
// output register between the byte sequencer and the response channel
// ----------------------------------------------------------------------------
module t1rbf_out (
   input  logic                clock,
   input  logic                reset,
   input  t1rbf_pkg::emit_type emit,
   output logic                take,
   t1rbf_rsp_if.source         rsp_ch
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   // register is free when empty or its byte transfers this cycle
   assign take = ~valid_ff | rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = emit.valid;
         byte_in  = emit.data;
         last_in  = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.last_byte = last_ff;

endmodule

@@ hw/rtl/t1_response_block_framer.sv @@
// ----------------------------------------------------------------------------
// t1_response_block_framer
// frames a t=1 response block with crc-16/x-25 as a byte stream
// ----------------------------------------------------------------------------
// A header item produces NAD (nibbles swapped), response PCB and LEN and
// opens a block unless LEN is zero; each payload byte of an open block
// produces itself; the block closes with the two CRC bytes, low byte
// first, last_byte on the second. The output carries one byte per
// transfer, and an item produces one byte for a payload byte, three for a
// header or for the final payload byte, five for a header with LEN zero,
// and none for a payload item with no block open, which is dropped. Each
// byte is registered in the output register before it leaves, and the
// next item is taken in the cycle the current one emits its last byte.
// ----------------------------------------------------------------------------
module t1_response_block_framer (
   input  logic        clock,
   input  logic        reset,
   t1rbf_req_if.sink   req_ch,
   t1rbf_rsp_if.source rsp_ch
);

   t1rbf_pkg::emit_type emit;
   logic                take;

   t1rbf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .emit   (emit)
   );

   t1rbf_out u_out (
      .clock  (clock),
      .reset  (reset),
      .emit   (emit),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

endmodule
